// ===== rtl/core/cgs_pkg.sv =====
// ============================================================================
// cgs_pkg
// Shared types, widths, codes and saturating arithmetic helpers for the
// conjugate gradient sparse solver.
// ============================================================================
`default_nettype none

package cgs_pkg;

   // Parameter defaults
   localparam int DEF_MAX_DOF     = 64;
   localparam int DEF_MAX_ENTRIES = 1024;
   localparam int DEF_FRAC_BITS   = 32;

   // Field widths
   localparam int VAL_W  = 64;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int TOL_W  = 63;
   localparam int TRIP_W = VAL_W + 2 * IDX_W;
   localparam int REQ_W  = 208;
   localparam int RSP_W  = 80;

   localparam logic [VAL_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      OPC_CLEAR = 2'd0,
      OPC_ADD   = 2'd1,
      OPC_LOAD  = 2'd2,
      OPC_SOLVE = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_DOF = 1'b0,
      CSR_TOL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             sat;
      logic [VAL_W-1:0] value;
   } sat_val_type;

   // Result of a multi-cycle arithmetic unit
   typedef struct packed {
      logic             done;
      logic             sat;
      logic [VAL_W-1:0] value;
   } unit_rsp_type;

   // Magnitude of a two's complement value
   function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
      mag = v[VAL_W-1] ? (64'd0 - v) : v;
   endfunction

   // Apply sign to a magnitude, clamping to the signed range
   function automatic sat_val_type from_mag(input logic [VAL_W-1:0] m,
                                            input logic neg, input logic over);
      sat_val_type      r;
      logic [VAL_W-1:0] lim;
      logic [VAL_W-1:0] mm;
      lim   = neg ? NEG_MIN : POS_MAX;
      r.sat = over || (m > lim);
      mm    = r.sat ? lim : m;
      r.value = neg ? (64'd0 - mm) : mm;
      return r;
   endfunction

   function automatic sat_val_type sadd(input logic [VAL_W-1:0] a,
                                        input logic [VAL_W-1:0] b);
      sat_val_type      r;
      logic [VAL_W-1:0] s;
      s     = a + b;
      r.sat = (a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1]);
      r.value = r.sat ? (a[VAL_W-1] ? NEG_MIN : POS_MAX) : s;
      return r;
   endfunction

   function automatic sat_val_type ssub(input logic [VAL_W-1:0] a,
                                        input logic [VAL_W-1:0] b);
      sat_val_type      r;
      logic [VAL_W-1:0] s;
      s     = a - b;
      r.sat = (a[VAL_W-1] != b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1]);
      r.value = r.sat ? (a[VAL_W-1] ? NEG_MIN : POS_MAX) : s;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cgs_ram.sv =====
// ============================================================================
// cgs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds until the next read.
// ============================================================================
`default_nettype none

module cgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cgs_mul.sv =====
// ============================================================================
// cgs_mul
// Saturating signed fixed-point multiplier. Four 32x32 partial products,
// one per cycle, accumulated into a 128-bit magnitude, then scaled.
// ============================================================================
`default_nettype none

module cgs_mul
   import cgs_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [VAL_W-1:0]   a,
   input  wire logic [VAL_W-1:0]   b,
   output unit_rsp_type            rsp
);

   logic [VAL_W-1:0]   x_ff, y_ff;
   logic               neg_ff;
   logic [2:0]         step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [31:0]        x_half, y_half;
   logic [VAL_W-1:0]   pp_ff;
   logic [1:0]         units_ff;
   logic [2*VAL_W-1:0] acc_ff;
   logic [2*VAL_W-1:0] pp_ext;
   sat_val_type        fin;
   sat_val_type        res_ff;

   // Select operand halves: bit 1 picks the x half, bit 0 the y half
   assign x_half = step_ff[1] ? x_ff[63:32] : x_ff[31:0];
   assign y_half = step_ff[0] ? y_ff[63:32] : y_ff[31:0];

   always_comb begin
      case (units_ff)
         2'd0:    pp_ext = {64'd0, pp_ff};
         2'd1:    pp_ext = {32'd0, pp_ff, 32'd0};
         default: pp_ext = {pp_ff, 64'd0};
      endcase
   end

   assign fin = from_mag(acc_ff[VAL_W-1+FRAC_BITS:FRAC_BITS], neg_ff,
                         |acc_ff[2*VAL_W-1:VAL_W+FRAC_BITS]);

   // Control sequence
   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath: load, multiply, accumulate, scale
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= mag(a);
         y_ff   <= mag(b);
         neg_ff <= a[VAL_W-1] ^ b[VAL_W-1];
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (step_ff < 3'd4) begin
            pp_ff    <= x_half * y_half;
            units_ff <= {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
         end
         if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
            acc_ff <= acc_ff + pp_ext;
         end
         if (step_ff == 3'd5) begin
            res_ff <= fin;
         end
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.sat   = res_ff.sat;
   assign rsp.value = res_ff.value;

endmodule

`default_nettype wire

// ===== rtl/core/cgs_div.sv =====
// ============================================================================
// cgs_div
// Saturating signed fixed-point divider, restoring, one quotient bit per
// cycle over the 128-bit scaled dividend.
// ============================================================================
`default_nettype none

module cgs_div
   import cgs_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [VAL_W-1:0] num,
   input  wire logic [VAL_W-1:0] den,
   output unit_rsp_type          rsp
);

   logic [2*VAL_W-1:0] dvd_ff;
   logic [VAL_W-1:0]   d_ff, rem_ff, q_ff;
   logic               over_ff, neg_ff;
   logic [6:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [VAL_W:0]     rem_sh;
   logic               fits;
   sat_val_type        res_ff;

   assign rem_sh = {rem_ff, dvd_ff[2*VAL_W-1]};
   assign fits   = rem_sh >= {1'b0, d_ff};

   // Control: 128 steps, then a final step to apply sign
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = 7'd127;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 7'd0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   // Datapath: shift in a dividend bit, compare, subtract
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff  <= {64'd0, mag(num)} << FRAC_BITS;
         d_ff    <= mag(den);
         rem_ff  <= '0;
         q_ff    <= '0;
         over_ff <= 1'b0;
         neg_ff  <= num[VAL_W-1] ^ den[VAL_W-1];
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         if (q_ff[VAL_W-1]) begin
            over_ff <= 1'b1;
         end
         if (fits) begin
            rem_ff <= VAL_W'(rem_sh - {1'b0, d_ff});
            q_ff   <= {q_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[VAL_W-1:0];
            q_ff   <= {q_ff[VAL_W-2:0], 1'b0};
         end
      end else if (fin_ff) begin
         res_ff <= from_mag(q_ff, neg_ff, over_ff);
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.sat   = res_ff.sat;
   assign rsp.value = res_ff.value;

endmodule

`default_nettype wire

// ===== rtl/core/conjugate_gradient_sparse_solver_top.sv =====
// ============================================================================
// conjugate_gradient_sparse_solver_top
// Conjugate gradient solver for K u = f over a coordinate-list matrix held
// in RAM, with vectors in RAM and shared multiply and divide units.
// ============================================================================
//
//  Channel  Dir  Handshake             Contents
//  req_     in   tvalid/tready         tdata: opcode, row, col, matrix, rhs, guess
//  rsp_     out  tvalid/tready/tlast   tdata: index, value, iterations, flags
//  csr_     in   we                    addr 0 dof_count, addr 1 tolerance
//
//  Load items (clear, add triplet, load vector entry) are taken in the idle state.
//  A solve runs a K*v product over the in-range triplets, dot products and
//  vector updates over the elements, and divides for alpha and beta; the
//  multiplier and the divider (one bit a cycle) set its run time.
//  Solution entries leave one at a time through an output register; the
//  next item is taken while the last one waits. Reset is synchronous; a
//  stalled output holds the sequencer only in the output phase.
// ============================================================================
`default_nettype none

module conjugate_gradient_sparse_solver_top
   import cgs_pkg::*;
#(
   parameter int MAX_DOF     = DEF_MAX_DOF,
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // opcode[1:0], row_index[7:2], col_index[13:8], matrix_value[77:14],
   // rhs_value[141:78], guess_value[205:142], zero pad
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // dof_index[5:0], solution_value[69:6], iterations_used[76:70],
   // converged[77], saturated[78], zero pad
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tvalid,
   output logic                  rsp_tlast,
   input  wire logic             rsp_tready,
   input  wire logic             csr_we,
   input  wire logic             csr_addr,
   input  wire logic [TOL_W-1:0] csr_wdata
);

   localparam int DW   = $clog2(MAX_DOF);
   localparam int EW   = (DW > CNT_W) ? DW : CNT_W;
   localparam int XW   = (DW > IDX_W) ? DW : IDX_W;
   localparam int AW   = $clog2(MAX_ENTRIES);
   localparam int TW   = $clog2(MAX_ENTRIES + 1);
   localparam int NCAP = (MAX_DOF < 64) ? MAX_DOF : 64;

   typedef enum logic [16:0] {
      S_IDLE = 17'h00001,
      S_CLR  = 17'h00002,
      S_KRD  = 17'h00004,
      S_KCHK = 17'h00008,
      S_KMS  = 17'h00010,
      S_KMW  = 17'h00020,
      S_VRD  = 17'h00040,
      S_VMA  = 17'h00080,
      S_VWA  = 17'h00100,
      S_VMB  = 17'h00200,
      S_VWB  = 17'h00400,
      S_PEND = 17'h00800,
      S_LOOP = 17'h01000,
      S_DIVS = 17'h02000,
      S_DIVW = 17'h04000,
      S_ORD  = 17'h08000,
      S_OLD  = 17'h10000
   } state_type;

   typedef enum logic [2:0] {
      PH_KU, PH_INIT, PH_KP, PH_PKP, PH_RR, PH_UPD, PH_RRN, PH_DIR
   } phase_type;

   // Input fields
   opcode_type       req_opc;
   logic [IDX_W-1:0] req_row, req_col;
   logic [VAL_W-1:0] req_mat, req_rhs, req_guess;
   logic             req_acc;

   assign req_opc   = opcode_type'(req_tdata[1:0]);
   assign req_row   = req_tdata[7:2];
   assign req_col   = req_tdata[13:8];
   assign req_mat   = req_tdata[77:14];
   assign req_rhs   = req_tdata[141:78];
   assign req_guess = req_tdata[205:142];

   // Registers
   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] i_ff, i_in, n_ff, n_in, iters_ff, iters_in;
   logic [CNT_W-1:0] dof_ff, dof_in, n_calc;
   logic [TOL_W-1:0] tol_ff, tol_in;
   logic [TW-1:0]    count_ff, count_in, t_ff, t_in;
   logic [VAL_W-1:0] acc_ff, acc_in, pkp_ff, pkp_in, rr_ff, rr_in, rrn_ff, rrn_in;
   logic [VAL_W-1:0] alpha_ff, alpha_in, beta_ff, beta_in, tmp_ff, tmp_in;
   logic             sat_ff, sat_in, conv_ff, conv_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   // Memory ports
   logic              trip_we, trip_re;
   logic [TRIP_W-1:0] trip_rd;
   logic              rhs_we, sol_we, res_we, dir_we, prod_we;
   logic              vec_re, sol_re, dir_re, prod_re;
   logic [DW-1:0]     sol_waddr, sol_raddr, dir_raddr, prod_waddr, prod_raddr;
   logic [VAL_W-1:0]  sol_wdata, res_wdata, dir_wdata, prod_wdata;
   logic [VAL_W-1:0]  rhs_rd, sol_rd, res_rd, dir_rd, prod_rd;

   // Index conversions
   logic [EW-1:0]    i_ext;
   logic [DW-1:0]    i_addr;
   logic [XW-1:0]    row_ext, tr_ext, tc_ext;
   logic [DW-1:0]    row_addr, tr_addr, tc_addr;
   logic [IDX_W-1:0] t_row, t_col;
   logic [VAL_W-1:0] t_val;
   logic             i_last, t_last, k_hit, row_ok;

   assign i_ext    = EW'(i_ff);
   assign i_addr   = i_ext[DW-1:0];
   assign row_ext  = XW'(req_row);
   assign row_addr = row_ext[DW-1:0];
   assign row_ok   = int'(req_row) < MAX_DOF;
   assign t_row    = trip_rd[IDX_W-1:0];
   assign t_col    = trip_rd[2*IDX_W-1:IDX_W];
   assign t_val    = trip_rd[TRIP_W-1:2*IDX_W];
   assign tr_ext   = XW'(t_row);
   assign tc_ext   = XW'(t_col);
   assign tr_addr  = tr_ext[DW-1:0];
   assign tc_addr  = tc_ext[DW-1:0];
   assign i_last   = (i_ff + 7'd1) == n_ff;
   assign t_last   = (t_ff + TW'(1)) == count_ff;
   assign k_hit    = ({1'b0, t_row} < n_ff) && ({1'b0, t_col} < n_ff);

   // Clamp the unknown count to the vector store and to 1..64
   always_comb begin
      if (dof_ff == 7'd0) begin
         n_calc = 7'd1;
      end else if (int'(dof_ff) > NCAP) begin
         n_calc = CNT_W'(NCAP);
      end else begin
         n_calc = dof_ff;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign req_acc    = req_tvalid && req_tready;

   // Arithmetic units
   logic         mul_start, div_start;
   logic [63:0]  mul_a, mul_b, div_num, div_den;
   unit_rsp_type mul_rsp, div_rsp;

   always_comb begin
      mul_a = alpha_ff;
      mul_b = dir_rd;
      if (state_ff == S_KMS) begin
         mul_a = t_val;
         mul_b = (phase_ff == PH_KU) ? sol_rd : dir_rd;
      end else if (state_ff == S_VMB) begin
         mul_b = prod_rd;
      end else begin
         case (phase_ff)
            PH_PKP: begin
               mul_a = dir_rd;
               mul_b = prod_rd;
            end
            PH_RR, PH_RRN: begin
               mul_a = res_rd;
               mul_b = res_rd;
            end
            PH_DIR:  mul_a = beta_ff;
            default: mul_a = alpha_ff;
         endcase
      end
   end

   assign mul_start = (state_ff == S_KMS) || (state_ff == S_VMB) ||
                      ((state_ff == S_VMA) && (phase_ff != PH_INIT));
   assign div_start = state_ff == S_DIVS;
   assign div_num   = (phase_ff == PH_RR) ? rr_ff : rrn_ff;
   assign div_den   = (phase_ff == PH_RR) ? pkp_ff : rr_ff;

   cgs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .rsp   (mul_rsp)
   );

   cgs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .rsp   (div_rsp)
   );

   // Shared saturating adder
   logic [VAL_W-1:0] add_a, add_b;
   logic             add_sub, add_use;
   sat_val_type      add_res;

   always_comb begin
      add_a   = acc_ff;
      add_b   = mul_rsp.value;
      add_sub = 1'b0;
      if (state_ff == S_KMW) begin
         add_a = prod_rd;
      end else if (state_ff == S_VMA) begin
         add_a   = rhs_rd;
         add_b   = prod_rd;
         add_sub = 1'b1;
      end else if (state_ff == S_VWB) begin
         add_a   = res_rd;
         add_sub = 1'b1;
      end else if (phase_ff == PH_UPD) begin
         add_a = sol_rd;
      end else if (phase_ff == PH_DIR) begin
         add_a = res_rd;
      end
   end

   assign add_res = add_sub ? ssub(add_a, add_b) : sadd(add_a, add_b);
   assign add_use = ((state_ff == S_VMA) && (phase_ff == PH_INIT)) ||
                    (mul_rsp.done && ((state_ff == S_KMW) || (state_ff == S_VWA) ||
                                      (state_ff == S_VWB)));

   // Memory control
   assign trip_we   = req_acc && (req_opc == OPC_ADD) && (count_ff < TW'(MAX_ENTRIES));
   assign trip_re   = state_ff == S_KRD;
   assign rhs_we    = req_acc && (req_opc == OPC_LOAD) && row_ok;
   assign vec_re    = state_ff == S_VRD;
   assign sol_re    = vec_re || (state_ff == S_ORD) ||
                      ((state_ff == S_KCHK) && k_hit && (phase_ff == PH_KU));
   assign dir_re    = vec_re || ((state_ff == S_KCHK) && k_hit && (phase_ff == PH_KP));
   assign prod_re   = vec_re || ((state_ff == S_KCHK) && k_hit);
   assign sol_raddr = (state_ff == S_KCHK) ? tc_addr : i_addr;
   assign dir_raddr = (state_ff == S_KCHK) ? tc_addr : i_addr;
   assign prod_raddr = (state_ff == S_KCHK) ? tr_addr : i_addr;

   assign sol_we    = rhs_we || ((state_ff == S_VWB) && mul_rsp.done);
   assign sol_waddr = (state_ff == S_IDLE) ? row_addr : i_addr;
   assign sol_wdata = (state_ff == S_IDLE) ? req_guess : tmp_ff;

   assign res_we    = ((state_ff == S_VMA) && (phase_ff == PH_INIT)) ||
                      ((state_ff == S_VWB) && mul_rsp.done);
   assign res_wdata = add_res.value;
   assign dir_we    = ((state_ff == S_VMA) && (phase_ff == PH_INIT)) ||
                      ((state_ff == S_VWA) && mul_rsp.done && (phase_ff == PH_DIR));
   assign dir_wdata = add_res.value;

   assign prod_we    = (state_ff == S_CLR) || ((state_ff == S_KMW) && mul_rsp.done);
   assign prod_waddr = (state_ff == S_CLR) ? i_addr : tr_addr;
   assign prod_wdata = (state_ff == S_CLR) ? '0 : add_res.value;

   cgs_ram #(.WIDTH(TRIP_W), .DEPTH(MAX_ENTRIES)) u_trip_ram (
      .clock (clock),
      .we    (trip_we),
      .waddr (count_ff[AW-1:0]),
      .wdata ({req_mat, req_col, req_row}),
      .re    (trip_re),
      .raddr (t_ff[AW-1:0]),
      .rdata (trip_rd)
   );

   cgs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF)) u_rhs_ram (
      .clock (clock),
      .we    (rhs_we),
      .waddr (row_addr),
      .wdata (req_rhs),
      .re    (vec_re),
      .raddr (i_addr),
      .rdata (rhs_rd)
   );

   cgs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF)) u_sol_ram (
      .clock (clock),
      .we    (sol_we),
      .waddr (sol_waddr),
      .wdata (sol_wdata),
      .re    (sol_re),
      .raddr (sol_raddr),
      .rdata (sol_rd)
   );

   cgs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF)) u_res_ram (
      .clock (clock),
      .we    (res_we),
      .waddr (i_addr),
      .wdata (res_wdata),
      .re    (vec_re),
      .raddr (i_addr),
      .rdata (res_rd)
   );

   cgs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF)) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (i_addr),
      .wdata (dir_wdata),
      .re    (dir_re),
      .raddr (dir_raddr),
      .rdata (dir_rd)
   );

   cgs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF)) u_prod_ram (
      .clock (clock),
      .we    (prod_we),
      .waddr (prod_waddr),
      .wdata (prod_wdata),
      .re    (prod_re),
      .raddr (prod_raddr),
      .rdata (prod_rd)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      iters_in     = iters_ff;
      dof_in       = dof_ff;
      tol_in       = tol_ff;
      count_in     = count_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      pkp_in       = pkp_ff;
      rr_in        = rr_ff;
      rrn_in       = rrn_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      tmp_in       = tmp_ff;
      conv_in      = conv_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sat_in       = sat_ff || (add_use && add_res.sat) ||
                     (mul_rsp.done && mul_rsp.sat) || (div_rsp.done && div_rsp.sat);

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_DOF: dof_in = csr_wdata[CNT_W-1:0];
            CSR_TOL: tol_in = csr_wdata;
            default: dof_in = dof_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_opc)
                  OPC_CLEAR: count_in = '0;
                  OPC_ADD: begin
                     if (trip_we) begin
                        count_in = count_ff + TW'(1);
                     end
                  end
                  OPC_LOAD: count_in = count_ff;
                  OPC_SOLVE: begin
                     n_in     = n_calc;
                     sat_in   = 1'b0;
                     conv_in  = 1'b0;
                     iters_in = '0;
                     i_in     = '0;
                     phase_in = PH_KU;
                     state_in = S_CLR;
                  end
                  default: count_in = count_ff;
               endcase
            end
         end
         // Zero the product vector before accumulating K*v
         S_CLR: begin
            if (i_last) begin
               t_in     = '0;
               state_in = (count_ff == '0) ? S_PEND : S_KRD;
            end else begin
               i_in = i_ff + 7'd1;
            end
         end
         S_KRD: state_in = S_KCHK;
         S_KCHK: begin
            if (k_hit) begin
               state_in = S_KMS;
            end else if (t_last) begin
               state_in = S_PEND;
            end else begin
               t_in     = t_ff + TW'(1);
               state_in = S_KRD;
            end
         end
         S_KMS: state_in = S_KMW;
         S_KMW: begin
            if (mul_rsp.done) begin
               if (t_last) begin
                  state_in = S_PEND;
               end else begin
                  t_in     = t_ff + TW'(1);
                  state_in = S_KRD;
               end
            end
         end
         S_VRD: state_in = S_VMA;
         S_VMA: begin
            if (phase_ff != PH_INIT) begin
               state_in = S_VWA;
            end else if (i_last) begin
               state_in = S_PEND;
            end else begin
               i_in     = i_ff + 7'd1;
               state_in = S_VRD;
            end
         end
         S_VWA: begin
            if (mul_rsp.done) begin
               if (phase_ff == PH_UPD) begin
                  tmp_in   = add_res.value;
                  state_in = S_VMB;
               end else begin
                  if (phase_ff != PH_DIR) begin
                     acc_in = add_res.value;
                  end
                  if (i_last) begin
                     state_in = S_PEND;
                  end else begin
                     i_in     = i_ff + 7'd1;
                     state_in = S_VRD;
                  end
               end
            end
         end
         S_VMB: state_in = S_VWB;
         S_VWB: begin
            if (mul_rsp.done) begin
               if (i_last) begin
                  state_in = S_PEND;
               end else begin
                  i_in     = i_ff + 7'd1;
                  state_in = S_VRD;
               end
            end
         end
         // End of a pass: pick the next step of the iteration
         S_PEND: begin
            i_in   = '0;
            acc_in = '0;
            case (phase_ff)
               PH_KU: begin
                  phase_in = PH_INIT;
                  state_in = S_VRD;
               end
               PH_INIT: state_in = S_LOOP;
               PH_KP: begin
                  phase_in = PH_PKP;
                  state_in = S_VRD;
               end
               PH_PKP: begin
                  pkp_in = acc_ff;
                  if (acc_ff == '0) begin
                     state_in = S_ORD;
                  end else begin
                     phase_in = PH_RR;
                     state_in = S_VRD;
                  end
               end
               PH_RR: begin
                  rr_in    = acc_ff;
                  state_in = S_DIVS;
               end
               PH_UPD: begin
                  phase_in = PH_RRN;
                  state_in = S_VRD;
               end
               PH_RRN: begin
                  rrn_in = acc_ff;
                  if (rr_ff == '0) begin
                     beta_in  = '0;
                     phase_in = PH_DIR;
                     state_in = S_VRD;
                  end else begin
                     state_in = S_DIVS;
                  end
               end
               default: begin
                  iters_in = iters_ff + 7'd1;
                  if (!rrn_ff[VAL_W-1] && (rrn_ff[TOL_W-1:0] < tol_ff)) begin
                     conv_in  = 1'b1;
                     state_in = S_ORD;
                  end else begin
                     state_in = S_LOOP;
                  end
               end
            endcase
         end
         S_LOOP: begin
            i_in = '0;
            if (iters_ff < n_ff) begin
               phase_in = PH_KP;
               state_in = S_CLR;
            end else begin
               state_in = S_ORD;
            end
         end
         S_DIVS: state_in = S_DIVW;
         S_DIVW: begin
            if (div_rsp.done) begin
               i_in   = '0;
               acc_in = '0;
               if (phase_ff == PH_RR) begin
                  alpha_in = div_rsp.value;
                  phase_in = PH_UPD;
               end else begin
                  beta_in  = div_rsp.value;
                  phase_in = PH_DIR;
               end
               state_in = S_VRD;
            end
         end
         S_ORD: state_in = S_OLD;
         // Load one solution entry into the output register
         S_OLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = i_last;
               rsp_data_in  = {1'b0, sat_ff, conv_ff, iters_ff, sol_rd, i_ff[IDX_W-1:0]};
               if (i_last) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 7'd1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_KU;
         i_ff         <= '0;
         n_ff         <= 7'd1;
         iters_ff     <= '0;
         dof_ff       <= 7'd64;
         tol_ff       <= '0;
         count_ff     <= '0;
         t_ff         <= '0;
         sat_ff       <= 1'b0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         i_ff         <= i_in;
         n_ff         <= n_in;
         iters_ff     <= iters_in;
         dof_ff       <= dof_in;
         tol_ff       <= tol_in;
         count_ff     <= count_in;
         t_ff         <= t_in;
         sat_ff       <= sat_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      pkp_ff      <= pkp_in;
      rr_ff       <= rr_in;
      rrn_ff      <= rrn_in;
      alpha_ff    <= alpha_in;
      beta_ff     <= beta_in;
      tmp_ff      <= tmp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
